/* hw/rtl/miller_rabin_primality_64_unit_defines.svh */
// Assertion macros for the Miller-Rabin unit.
`ifndef MILLER_RABIN_PRIMALITY_64_UNIT_DEFINES_SVH
`define MILLER_RABIN_PRIMALITY_64_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MRP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MRP_ASSERT_SAME(label, clk, rst, ante, cons)
`define MRP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/mrp_pkg.sv */
// ----------------------------------------------------------------------------
// mrp_pkg
// Types and constants shared by the Miller-Rabin unit.
// ----------------------------------------------------------------------------
package mrp_pkg;

  localparam int MAX_BASES = 12;
  localparam int BASE_IDX_W = 4;

  localparam logic [7:0] BASE_TABLE [MAX_BASES] = '{
    8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19, 8'd23, 8'd29, 8'd31, 8'd37
  };

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SHIFT = 9'b000000010,
    S_BASE  = 9'b000000100,
    S_EXP   = 9'b000001000,
    S_MULX  = 9'b000010000,
    S_MULP  = 9'b000100000,
    S_CHECK = 9'b001000000,
    S_SQ    = 9'b010000000,
    S_SQW   = 9'b100000000
  } state_t;

endpackage

/* hw/rtl/miller_rabin_primality_64_unit.sv */
// Values below 4 and even values are answered without leaving idle; all others are
// tested over the base set with the shared bit-serial modular multiplier (one
// bit of the multiplier per cycle).
// Throughput: one transaction at a time; busy is high until the result strobe.
// Reset: synchronous, active high; returns to idle with no result pending.
// Results are strobed on done for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// miller_rabin_primality_64_unit
// Miller-Rabin test over a fixed prime base set with a shared mulmod unit.
// ----------------------------------------------------------------------------
`include "miller_rabin_primality_64_unit_defines.svh"

module miller_rabin_primality_64_unit #(
  parameter int WORD_BITS  = 64,
  parameter int BASE_COUNT = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] candidate,
  output logic        busy,
  output logic        done,
  output logic        is_prime
);
  import mrp_pkg::*;

  localparam int W     = WORD_BITS;
  localparam int COUNT = (BASE_COUNT > MAX_BASES) ? MAX_BASES : BASE_COUNT;
  localparam int KW    = $clog2(COUNT + 1);
  localparam int RW    = $clog2(W);

  state_t        state;
  logic [W-1:0]  n;
  logic [W-1:0]  nm1;
  logic [W-1:0]  d;
  logic [W-1:0]  e;
  logic [W-1:0]  x;
  logic [W-1:0]  p;
  logic [RW-1:0] r;
  logic [RW-1:0] i;
  logic [KW-1:0] k;
  logic          mul_go;
  logic [W-1:0]  mul_a;
  logic [W-1:0]  mul_b;
  logic          mul_done;
  logic [W-1:0]  mul_res;
  logic [W-1:0]  cand;
  logic [W-1:0]  base_val;

  assign cand     = candidate[W-1:0];
  assign base_val = W'(BASE_TABLE[BASE_IDX_W'(k)]);
  assign busy     = (state != S_IDLE);

  mrp_mulmod #(.W(W)) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .go     (mul_go),
    .a      (mul_a),
    .b      (mul_b),
    .m      (n),
    .done   (mul_done),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      mul_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      mul_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (cand < W'(2)) begin
              done <= 1'b1; is_prime <= 1'b0;
            end else if (cand == W'(2) || cand == W'(3)) begin
              done <= 1'b1; is_prime <= 1'b1;
            end else if (!cand[0]) begin
              done <= 1'b1; is_prime <= 1'b0;
            end else begin
              n     <= cand;
              nm1   <= cand - W'(1);
              d     <= cand - W'(1);
              r     <= '0;
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (d[0]) begin
            k     <= '0;
            state <= S_BASE;
          end else begin
            d <= d >> 1;
            r <= r + RW'(1);
          end
        end
        S_BASE: begin
          if (k == KW'(COUNT)) begin
            done <= 1'b1; is_prime <= 1'b1;
            state <= S_IDLE;
          end else if (base_val >= n) begin
            k <= k + KW'(1);
          end else begin
            x     <= W'(1);
            p     <= base_val;
            e     <= d;
            state <= S_EXP;
          end
        end
        S_EXP: begin
          if (e == '0) begin
            state <= S_CHECK;
          end else begin
            mul_go <= 1'b1;
            if (e[0]) begin
              mul_a <= x; mul_b <= p; state <= S_MULX;
            end else begin
              mul_a <= p; mul_b <= p; state <= S_MULP;
            end
          end
        end
        S_MULX: begin
          if (mul_done) begin
            x      <= mul_res;
            mul_go <= 1'b1;
            mul_a  <= p;
            mul_b  <= p;
            state  <= S_MULP;
          end
        end
        S_MULP: begin
          if (mul_done) begin
            p     <= mul_res;
            e     <= e >> 1;
            state <= S_EXP;
          end
        end
        S_CHECK: begin
          if (x == W'(1) || x == nm1) begin
            k     <= k + KW'(1);
            state <= S_BASE;
          end else begin
            i     <= RW'(1);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (i >= r) begin
            done <= 1'b1; is_prime <= 1'b0;
            state <= S_IDLE;
          end else begin
            mul_go <= 1'b1;
            mul_a  <= x;
            mul_b  <= x;
            state  <= S_SQW;
          end
        end
        S_SQW: begin
          if (mul_done) begin
            x <= mul_res;
            if (mul_res == nm1) begin
              k     <= k + KW'(1);
              state <= S_BASE;
            end else begin
              i     <= i + RW'(1);
              state <= S_SQ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MRP_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `MRP_ASSERT_NEXT(a_accept_moves, clk, rst, start && !busy, busy || done)
  `MRP_ASSERT_SAME(a_fall_done, clk, rst, $fell(busy), done)

endmodule

/* hw/rtl/mrp_mulmod.sv */
// ----------------------------------------------------------------------------
// mrp_mulmod
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle.
// ----------------------------------------------------------------------------
module mrp_mulmod #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] result
);
  import mrp_pkg::*;

  logic         run;
  logic [W-1:0] acc;
  logic [W-1:0] aa;
  logic [W-1:0] bb;
  logic [W-1:0] room_acc;
  logic [W-1:0] room_dbl;
  logic [W-1:0] acc_next;
  logic [W-1:0] aa_next;

  // operands stay below m, so wrapped differences are exact
  always_comb begin
    room_acc = m - aa;
    room_dbl = m - aa;
    acc_next = (acc >= room_acc) ? (acc - room_acc) : (acc + aa);
    aa_next  = (aa >= room_dbl) ? (aa - room_dbl) : (aa + aa);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        acc <= '0;
        aa  <= a;
        bb  <= b;
      end else if (run) begin
        if (bb == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          if (bb[0]) acc <= acc_next;
          aa <= aa_next;
          bb <= bb >> 1;
        end
      end
    end
  end

  assign result = acc;

endmodule
